FILE: src/glh_pkg.sv
// Shared types and constants for the gray-level histogram engine.
// No dependencies; used by glh_store and gray_level_histogram_top.
package glh_pkg;

	localparam int LEVEL_BITS     = 16;
	localparam int COUNT_BITS     = 32;
	localparam int NUM_LEVELS     = 1 << LEVEL_BITS;
	localparam int CURSOR_BITS    = LEVEL_BITS + 1;
	localparam int DISTINCT_BITS  = 17;
	localparam int OUT_LEVEL_BITS = 16;
	localparam int OUT_COUNT_BITS = 32;
	localparam int OUT_DATA_BITS  = OUT_LEVEL_BITS + OUT_COUNT_BITS + DISTINCT_BITS;
	localparam int TDATA_BITS     = ((OUT_DATA_BITS + 7) / 8) * 8;
	localparam int TDATA_PAD      = TDATA_BITS - OUT_DATA_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// operation codes carried in s_tuser
	localparam logic [1:0] OP_ACC   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic                  acc_start; // accumulate transfer taken at this edge
		logic [LEVEL_BITS-1:0] rd_addr;
		logic                  clr_we;
		logic [LEVEL_BITS-1:0] clr_addr;
	} mem_req_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] rd_data;
		logic                  new_level; // bin goes from zero to one this cycle
	} mem_rsp_t;

	// clamp a bin count to the width of the result field
	function automatic logic [OUT_COUNT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		if (w[63:32] != 32'd0) begin
			return '1;
		end
		return w[31:0];
	endfunction

endpackage

FILE: src/glh_store.sv
// Bin memory with the accumulate read-modify-write pipeline and forwarding.
// Depends on glh_pkg.
module glh_store (
	input  logic              clk,
	input  logic              arst_n,
	input  glh_pkg::mem_req_t req,
	output glh_pkg::mem_rsp_t rsp
);

	logic [glh_pkg::COUNT_BITS-1:0] mem [glh_pkg::NUM_LEVELS];
	logic [glh_pkg::COUNT_BITS-1:0] rd_q;

	logic                           acc_vld_s1;
	logic [glh_pkg::LEVEL_BITS-1:0] acc_addr_s1;

	// last accumulate write, for a read issued at the same edge
	logic                           fwd_vld_q;
	logic [glh_pkg::LEVEL_BITS-1:0] fwd_addr_q;
	logic [glh_pkg::COUNT_BITS-1:0] fwd_data_q;

	logic [glh_pkg::COUNT_BITS-1:0] old_cnt;
	logic [glh_pkg::COUNT_BITS-1:0] new_cnt;
	logic                           we;
	logic [glh_pkg::LEVEL_BITS-1:0] wa;
	logic [glh_pkg::COUNT_BITS-1:0] wd;

	always_comb begin
		old_cnt = (fwd_vld_q && fwd_addr_q == acc_addr_s1) ? fwd_data_q : rd_q;
		new_cnt = (old_cnt == glh_pkg::COUNT_MAX) ? old_cnt
			: old_cnt + glh_pkg::COUNT_BITS'(1);
		we      = acc_vld_s1 | req.clr_we;
		wa      = acc_vld_s1 ? acc_addr_s1 : req.clr_addr;
		wd      = acc_vld_s1 ? new_cnt : '0;
	end

	assign rsp.rd_data   = rd_q;
	assign rsp.new_level = acc_vld_s1 && (old_cnt == '0);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[req.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_s1 <= 1'b0;
			fwd_vld_q  <= 1'b0;
		end else begin
			acc_vld_s1 <= req.acc_start;
			fwd_vld_q  <= acc_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		acc_addr_s1 <= req.rd_addr;
		fwd_addr_q  <= acc_addr_s1;
		fwd_data_q  <= new_cnt;
	end

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc_vld_s1 && req.clr_we))
		else $error("accumulate write collides with clear sweep");

	a_bin_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		acc_vld_s1 |-> new_cnt != '0)
		else $error("accumulated bin written as zero");

	a_fwd_origin: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_vld_q |-> $past(acc_vld_s1))
		else $error("forwarding entry without a preceding accumulate write");

endmodule

FILE: src/gray_level_histogram_top.sv
// Gray-level histogram engine, top level: command decode, bin scan, result register.
// Depends on glh_pkg and glh_store.
//
// Usage:
//   Slave channel: one transfer per command. s_tuser holds the operation
//   (accumulate, read next bin, clear), s_tdata the pixel gray level.
//   Master channel: one transfer per read command. m_tdata holds level,
//   bin count and distinct-level total; m_tlast flags that no non-empty
//   bin remains (level and count are then zero).
// Throughput and pipelining:
//   Accumulates stream at one per cycle while s_tready is high. The bin memory
//   is read when the transfer is taken and written back in the cycle after;
//   a back-to-back hit on the same bin is served from a forwarding register.
//   A read walks the bin memory one level per cycle from the cursor; the
//   memory read port sets that pace. A clear sweeps the memory one bin per
//   cycle.
// Reset:
//   Reset starts the same clearing sweep; s_tready stays low until it finishes.
// Stalls:
//   The result waits in an output register while m_tready is low; new
//   commands are still taken, and a further read holds its result until
//   the register frees up.
module gray_level_histogram_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,   // [15:0] pixel_value
	input  logic [1:0]                   s_tuser,   // [1:0] op
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [15:0] level, [47:16] bin_count, [64:48] distinct_levels, rest zero
	output logic [glh_pkg::TDATA_BITS-1:0] m_tdata,
	output logic                         m_tlast    // no_more_bins
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;

	logic [glh_pkg::LEVEL_BITS-1:0]    clr_ptr_q;
	logic [glh_pkg::CURSOR_BITS-1:0]   issue_ptr_q;  // next level to read during a scan
	logic [glh_pkg::CURSOR_BITS-1:0]   cur_q;        // read cursor
	logic [glh_pkg::DISTINCT_BITS-1:0] distinct_q;

	logic                           chk_vld_s1;
	logic [glh_pkg::LEVEL_BITS-1:0] chk_addr_s1;

	logic [glh_pkg::LEVEL_BITS-1:0] res_level_q;
	logic [glh_pkg::COUNT_BITS-1:0] res_count_q;
	logic                           res_last_q;

	logic                              out_vld_q;
	logic [glh_pkg::OUT_LEVEL_BITS-1:0] out_level_q;
	logic [glh_pkg::OUT_COUNT_BITS-1:0] out_count_q;
	logic [glh_pkg::DISTINCT_BITS-1:0]  out_distinct_q;
	logic                              out_last_q;

	glh_pkg::mem_req_t req;
	glh_pkg::mem_rsp_t rsp;

	logic in_xfer;
	logic clear_xfer;
	logic hit;
	logic scan_end;
	logic out_free;
	logic out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign clear_xfer = in_xfer && (s_tuser == glh_pkg::OP_CLEAR);

	// a scanned bin is found once its read data comes back nonzero
	assign hit      = (state_q == ST_SCAN) && chk_vld_s1 && (rsp.rd_data != '0);
	assign scan_end = (state_q == ST_SCAN) && !hit && issue_ptr_q[glh_pkg::LEVEL_BITS];
	assign out_free = !out_vld_q || m_tready;
	assign out_load = (state_q == ST_EMIT) && out_free;

	always_comb begin
		req.acc_start = in_xfer && (s_tuser == glh_pkg::OP_ACC);
		req.rd_addr   = (state_q == ST_SCAN) ? issue_ptr_q[glh_pkg::LEVEL_BITS-1:0]
			: s_tdata[glh_pkg::LEVEL_BITS-1:0];
		req.clr_we    = (state_q == ST_CLEAR);
		req.clr_addr  = clr_ptr_q;
	end

	glh_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// control: sequencer, cursor, distinct total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_ptr_q   <= '0;
			issue_ptr_q <= '0;
			cur_q       <= '0;
			distinct_q  <= '0;
			chk_vld_s1  <= 1'b0;
		end else begin
			chk_vld_s1 <= (state_q == ST_SCAN) && !hit
				&& !issue_ptr_q[glh_pkg::LEVEL_BITS];

			// clear wins over a pending accumulate finishing at the same edge
			if (clear_xfer) begin
				distinct_q <= '0;
			end else if (rsp.new_level) begin
				distinct_q <= distinct_q + glh_pkg::DISTINCT_BITS'(1);
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_ptr_q <= clr_ptr_q + glh_pkg::LEVEL_BITS'(1);
					if (clr_ptr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						unique case (s_tuser)
							glh_pkg::OP_READ: begin
								issue_ptr_q <= cur_q;
								state_q     <= ST_SCAN;
							end
							glh_pkg::OP_CLEAR: begin
								clr_ptr_q <= '0;
								cur_q     <= '0;
								state_q   <= ST_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						cur_q   <= glh_pkg::CURSOR_BITS'(chk_addr_s1)
							+ glh_pkg::CURSOR_BITS'(1);
						state_q <= ST_EMIT;
					end else if (scan_end) begin
						cur_q   <= glh_pkg::CURSOR_BITS'(glh_pkg::NUM_LEVELS);
						state_q <= ST_EMIT;
					end else begin
						issue_ptr_q <= issue_ptr_q + glh_pkg::CURSOR_BITS'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan payload: address in flight and the result found
	always_ff @(posedge clk) begin
		chk_addr_s1 <= issue_ptr_q[glh_pkg::LEVEL_BITS-1:0];
		if (hit) begin
			res_level_q <= chk_addr_s1;
			res_count_q <= rsp.rd_data;
			res_last_q  <= 1'b0;
		end else if (scan_end) begin
			res_level_q <= '0;
			res_count_q <= '0;
			res_last_q  <= 1'b1;
		end
	end

	// output register: hold the result until the master side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_level_q    <= glh_pkg::OUT_LEVEL_BITS'(res_level_q);
			out_count_q    <= glh_pkg::sat_count(res_count_q);
			out_distinct_q <= distinct_q;
			out_last_q     <= res_last_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{glh_pkg::TDATA_PAD{1'b0}}, out_distinct_q, out_count_q, out_level_q};

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= glh_pkg::CURSOR_BITS'(glh_pkg::NUM_LEVELS))
		else $error("read cursor beyond the last level");

	a_no_stale_check: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !chk_vld_s1)
		else $error("scan read still in flight while taking commands");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (out_level_q == '0 && out_count_q == '0))
		else $error("end-of-bins result carries a level or count");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.acc_start)
		else $error("accumulate taken during clear sweep");

endmodule

FILE: sim/gray_level_histogram_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the gray-level histogram engine: keeps its own histogram copy,
// predicts a bin report for every read transfer and compares each result transfer.
// Depends on glh_pkg.
module gray_level_histogram_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [15:0]                    s_tdata,
	input  logic [1:0]                     s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [glh_pkg::TDATA_BITS-1:0] m_tdata,
	input  logic                           m_tlast,
	output int                             fail_count,
	output int                             pending,
	output int                             reports_checked,
	output int                             end_reports
);

	typedef struct packed {
		logic [glh_pkg::OUT_LEVEL_BITS-1:0] level;
		logic [glh_pkg::OUT_COUNT_BITS-1:0] count;
		logic [glh_pkg::DISTINCT_BITS-1:0]  distinct;
		logic                               last;
	} bin_report_t;

	bin_report_t                       expected_reports[$];
	logic [glh_pkg::COUNT_BITS-1:0]    hist_bins [glh_pkg::NUM_LEVELS];
	logic [glh_pkg::DISTINCT_BITS-1:0] seen_levels;
	logic [glh_pkg::CURSOR_BITS-1:0]   scan_cursor;

	task automatic clear_histogram();
		for (int i = 0; i < glh_pkg::NUM_LEVELS; i++) begin
			hist_bins[i] = '0;
		end
		seen_levels = '0;
		scan_cursor = '0;
	endtask

	task automatic predict_command(input logic [1:0] op, input logic [15:0] pixel);
		logic [glh_pkg::LEVEL_BITS-1:0] lvl;
		logic [63:0]                    wide;
		bin_report_t                    rep;
		case (op)
			glh_pkg::OP_ACC: begin
				lvl = pixel[glh_pkg::LEVEL_BITS-1:0];
				if (hist_bins[lvl] == '0) begin
					seen_levels = seen_levels + glh_pkg::DISTINCT_BITS'(1);
				end
				if (hist_bins[lvl] != glh_pkg::COUNT_MAX) begin
					hist_bins[lvl] = hist_bins[lvl] + glh_pkg::COUNT_BITS'(1);
				end
			end
			glh_pkg::OP_CLEAR: begin
				clear_histogram();
			end
			glh_pkg::OP_READ: begin
				// skip empty bins; the cursor parks at the end until a clear
				while (scan_cursor < glh_pkg::CURSOR_BITS'(glh_pkg::NUM_LEVELS)
						&& hist_bins[scan_cursor[glh_pkg::LEVEL_BITS-1:0]] == '0) begin
					scan_cursor = scan_cursor + glh_pkg::CURSOR_BITS'(1);
				end
				rep.distinct = seen_levels;
				if (scan_cursor >= glh_pkg::CURSOR_BITS'(glh_pkg::NUM_LEVELS)) begin
					rep.level = '0;
					rep.count = '0;
					rep.last  = 1'b1;
				end else begin
					wide      = 64'(hist_bins[scan_cursor[glh_pkg::LEVEL_BITS-1:0]]);
					rep.level = glh_pkg::OUT_LEVEL_BITS'(scan_cursor);
					rep.count = (wide > 64'hFFFF_FFFF) ? '1
						: wide[glh_pkg::OUT_COUNT_BITS-1:0];
					rep.last  = 1'b0;
					scan_cursor = scan_cursor + glh_pkg::CURSOR_BITS'(1);
				end
				expected_reports.push_back(rep);
			end
			default: begin
			end
		endcase
	endtask

	task automatic note_mismatch(input string what, input bin_report_t want, input bin_report_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t mismatch (%s): expected level %0d count %0d distinct %0d end %0b,",
				$realtime, what, want.level, want.count, want.distinct, want.last,
				" got level %0d count %0d distinct %0d end %0b",
				got.level, got.count, got.distinct, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bin_report_t got;
		bin_report_t want;
		if (!arst_n) begin
			clear_histogram();
			expected_reports.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got.level    = m_tdata[glh_pkg::OUT_LEVEL_BITS-1:0];
				got.count    = m_tdata[glh_pkg::OUT_LEVEL_BITS +: glh_pkg::OUT_COUNT_BITS];
				got.distinct = m_tdata[glh_pkg::OUT_LEVEL_BITS + glh_pkg::OUT_COUNT_BITS
					+: glh_pkg::DISTINCT_BITS];
				got.last     = m_tlast;
				if (expected_reports.size() == 0) begin
					note_mismatch("no read waiting", '0, got);
				end else begin
					want = expected_reports.pop_front();
					reports_checked++;
					if (want.last) begin
						end_reports++;
					end
					if (got.level != want.level || got.count != want.count ||
							got.distinct != want.distinct || got.last !== want.last) begin
						note_mismatch("field differs", want, got);
					end else if (m_tdata[glh_pkg::TDATA_BITS-1:glh_pkg::OUT_DATA_BITS] != '0) begin
						note_mismatch("fill bits not zero", want, got);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_command(s_tuser, s_tdata);
			end
		end
		pending = expected_reports.size();
	end

endmodule

FILE: sim/gray_level_histogram_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the gray-level histogram engine: clock, reset, command
// stimulus and result back-pressure; checking lives in gray_level_histogram_checker.
// Depends on glh_pkg, gray_level_histogram_top and gray_level_histogram_checker.
module gray_level_histogram_top_test;

	// the fourth op code has no meaning; the block must ignore it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int NUM_PHASES   = 4;
	localparam int PHASE_ITEMS  = 370;
	localparam int HOLD_CYCLES  = 400;
	localparam int WINDOW_SPAN  = 31;
	localparam int IDLE_PCT     = 16;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [15:0]                    s_tdata  = '0;               // [15:0] pixel_value
	logic [1:0]                     s_tuser  = glh_pkg::OP_ACC;  // [1:0] op
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	// [15:0] level, [47:16] bin_count, [64:48] distinct_levels, rest zero
	logic [glh_pkg::TDATA_BITS-1:0] m_tdata;
	logic                           m_tlast;                     // no_more_bins

	int fail_count;
	int pending;
	int reports_checked;
	int end_reports;

	int src_idle_pct  = IDLE_PCT;
	int sink_idle_pct = IDLE_PCT;
	int hold_requests = 0;

	int acc_sent;
	int read_sent;
	int clear_sent;
	int ignored_sent;

	gray_level_histogram_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	gray_level_histogram_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.fail_count      (fail_count),
		.pending         (pending),
		.reports_checked (reports_checked),
		.end_reports     (end_reports)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one command transfer. Optional idle cycles come first, with junk on
	// the data lines; valid stays high from one command to the next otherwise.
	task automatic send_command(input logic [1:0] op, input logic [15:0] pixel);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata  = 16'($urandom);
			s_tuser  = 2'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = pixel;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		case (op)
			glh_pkg::OP_ACC:   acc_sent++;
			glh_pkg::OP_READ:  read_sent++;
			glh_pkg::OP_CLEAR: clear_sent++;
			default:           ignored_sent++;
		endcase
	endtask

	// Drop valid and hold until every predicted bin report has come back.
	task automatic wait_for_drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	// Mostly levels inside a narrow window so reads find dense bins, some
	// anywhere in the range, some at the two extremes.
	function automatic logic [15:0] pick_pixel(input int window_base);
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) begin
			return 16'(window_base + $urandom_range(WINDOW_SPAN));
		end else if (sel < 90) begin
			return 16'($urandom);
		end else if (sel < 95) begin
			return '0;
		end
		return '1;
	endfunction

	// Result side: random back-pressure, plus a long hold-off whenever the
	// stimulus asks for one. The hold is counted here, in cycles.
	initial begin
		int hold_left;
		int holds_served;
		hold_left    = 0;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES - 1;
				m_tready  = 1'b0;
			end else begin
				m_tready = ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin
		int window_base;
		int read_pct;
		int sent;
		int sel;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Reading an empty histogram walks every bin and reports
		// the end with a zero distinct count; a clear then restarts the pass.
		send_command(glh_pkg::OP_READ, 16'h0000);
		send_command(glh_pkg::OP_CLEAR, 16'hFFFF);
		// both extremes of the level range and alternating bit patterns
		send_command(glh_pkg::OP_ACC, 16'h0000);
		send_command(glh_pkg::OP_ACC, 16'h0000);
		send_command(glh_pkg::OP_ACC, 16'hFFFF);
		send_command(glh_pkg::OP_ACC, 16'h5555);
		send_command(glh_pkg::OP_ACC, 16'hAAAA);
		// unused op code: nothing may change, nothing may come out
		send_command(OP_UNUSED, 16'h0007);
		send_command(OP_UNUSED, 16'hFFFF);
		send_command(glh_pkg::OP_READ, 16'h1234);
		// level zero gains a pixel behind the cursor: count grows, no repeat
		send_command(glh_pkg::OP_ACC, 16'h0000);
		send_command(glh_pkg::OP_READ, 16'h0000);
		// a brand-new level behind the cursor still raises the distinct total
		send_command(glh_pkg::OP_ACC, 16'h1234);
		send_command(glh_pkg::OP_READ, 16'h0000);
		send_command(glh_pkg::OP_READ, 16'h0000);
		// past the last bin: end flag, then the cursor stays parked there
		send_command(glh_pkg::OP_READ, 16'h0000);
		send_command(glh_pkg::OP_READ, 16'hFFFF);
		send_command(glh_pkg::OP_CLEAR, 16'h0000);

		// Random phases. Each ends with a clear, so no phase runs more than one
		// read pass; the cursor only moves up, which bounds the scan time.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// one whole phase with no idling on either side
			src_idle_pct  = (phase == 1) ? 0 : IDLE_PCT;
			sink_idle_pct = (phase == 1) ? 0 : IDLE_PCT;
			window_base   = $urandom_range(65535 - WINDOW_SPAN);
			read_pct      = 15 + $urandom_range(20);
			sent          = 0;
			while (sent < PHASE_ITEMS) begin
				// stall the result side for a long stretch while reads keep coming
				if (phase == 2 && sent == 60) begin
					hold_requests++;
				end
				// and once, let everything drain before going on
				if (phase == 3 && sent == PHASE_ITEMS / 2) begin
					wait_for_drain();
				end
				sel = $urandom_range(99);
				if (sel < 3) begin
					send_command(OP_UNUSED, 16'($urandom));
				end else if (sel < 3 + read_pct) begin
					send_command(glh_pkg::OP_READ, 16'($urandom));
					sent++;
				end else begin
					send_command(glh_pkg::OP_ACC, pick_pixel(window_base));
					sent++;
				end
			end
			send_command(glh_pkg::OP_CLEAR, 16'($urandom));
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		// give any stray result time to show up
		repeat (200) @(negedge clk);

		$display("Sent %0d accumulates, %0d reads, %0d clears, %0d ignored commands.",
			acc_sent, read_sent, clear_sent, ignored_sent);
		$display("Checked %0d bin reports, %0d of them end-of-bins; %0d mismatches.",
			reports_checked, end_reports, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (reset sweep, clears and
	// full read passes, plus every stall).
	initial begin
		#200_000_000;
		$display("Timeout with %0d bin reports outstanding.", pending);
		$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
src/glh_pkg.sv
src/glh_store.sv
src/gray_level_histogram_top.sv
sim/gray_level_histogram_checker.sv
sim/gray_level_histogram_top_test.sv
